// ----- sv/vp9bd_pkg.sv -----
// ----------------------------------------------------------------------------
// vp9bd_pkg
// Shared types and constants of the VP9 boolean decoder core.
// ----------------------------------------------------------------------------
package vp9bd_pkg;

  localparam int WINDOW_BITS_DEF      = 64;
  localparam int MAX_LITERAL_BITS_DEF = 16;

  localparam logic [1:0] MODE_PUSH    = 2'd0;
  localparam logic [1:0] MODE_START   = 2'd1;
  localparam logic [1:0] MODE_BOOL    = 2'd2;
  localparam logic [1:0] MODE_LITERAL = 2'd3;

  localparam logic [7:0] PROB_HALF  = 8'd128;
  localparam logic [7:0] RANGE_INIT = 8'd255;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [7:0] prob;
    logic [4:0] literal_bits;
  } vp9bd_in_t;

  typedef struct packed {
    logic [15:0] value;
    logic        underrun;
  } vp9bd_out_t;

endpackage

// ----- sv/vp9_bool_decoder_core.sv -----
// ----------------------------------------------------------------------------
// vp9_bool_decoder_core
// VP9 boolean arithmetic decoder: byte push, start, bool and literal decode.
// ----------------------------------------------------------------------------
// A push word only fills the window and gives no result. Start and bool words
// decode a single bit after acceptance, a literal of n bits decodes n bits
// (zero bits: none); the input is stalled until the result is loaded
// into the output register. All decisions go through one shared decode unit
// (normalise, 8x8 split multiply, compare, subtract) that yields one bit per cycle
// unless a word's last bit waits on a full, stalled output register. The output
// register lets the next word be accepted while a result still waits to be taken.
module vp9_bool_decoder_core #(
  parameter int WINDOW_BITS      = vp9bd_pkg::WINDOW_BITS_DEF,
  parameter int MAX_LITERAL_BITS = vp9bd_pkg::MAX_LITERAL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  vp9bd_pkg::vp9bd_in_t  in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output vp9bd_pkg::vp9bd_out_t out_word_o
);
  import vp9bd_pkg::*;

  localparam int W    = WINDOW_BITS;
  localparam int BcW  = $clog2(W + 1);
  localparam int CntW = $clog2(MAX_LITERAL_BITS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  function automatic logic [2:0] lead_zeros(input logic [7:0] r);
    logic [3:0] s;
    logic       found;
    s     = '0;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found) begin
        if (r[i]) found = 1'b1;
        else s = s + 4'd1;
      end
    end
    if (r == 8'd0) s = '0;
    return s[2:0];
  endfunction

  logic             state_q, state_d;
  logic [7:0]       range_q, range_d;
  logic [W-1:0]     window_q, window_d;
  logic [BcW-1:0]   bc_q, bc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [7:0]       prob_q, prob_d;
  logic [15:0]      acc_q, acc_d;
  logic             under_q, under_d;
  logic             out_valid_q;
  vp9bd_out_t       out_word_q;

  logic             accept, out_free, step, finish;

  // shared decode unit
  logic [2:0]       shift;
  logic [7:0]       r_n;
  logic [W-1:0]     win_sh;
  logic [BcW-1:0]   bc_sh;
  logic             dec_under;
  logic [15:0]      prod;
  logic [16:0]      split_sum;
  logic [7:0]       split;
  logic [7:0]       top;
  logic             dec_bit;
  logic [W-1:0]     dec_window;
  logic [7:0]       dec_range;
  logic [W-1:0]     push_bits;

  always_comb begin
    shift      = lead_zeros(range_q);
    r_n        = range_q << shift;
    win_sh     = window_q << shift;
    bc_sh      = (BcW'(shift) > bc_q) ? '0 : bc_q - BcW'(shift);
    dec_under  = (int'(bc_sh) < 8);
    prod       = r_n * prob_q;
    split_sum  = {1'b0, prod} + (17'd256 - {9'd0, prob_q});
    split      = split_sum[15:8];
    top        = win_sh[W-1 -: 8];
    dec_bit    = (top >= split);
    dec_window = win_sh;
    if (dec_bit) dec_window[W-1 -: 8] = top - split;
    dec_range  = dec_bit ? (r_n - split) : split;
  end

  assign push_bits  = {in_word_i.data_byte, {(W-8){1'b0}}} >> bc_q;
  assign in_stall_o = (state_q == ST_BUSY);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = (state_q == ST_BUSY) && (cnt_q != '0)
                      && ((cnt_q != CntW'(1)) || out_free);
  assign finish     = (state_q == ST_BUSY) && out_free
                      && ((cnt_q == '0) || (cnt_q == CntW'(1)));

  always_comb begin
    state_d  = state_q;
    range_d  = range_q;
    window_d = window_q;
    bc_d     = bc_q;
    cnt_d    = cnt_q;
    prob_d   = prob_q;
    acc_d    = acc_q;
    under_d  = under_q;
    if (accept) begin
      acc_d   = '0;
      under_d = 1'b0;
      prob_d  = PROB_HALF;
      unique case (in_word_i.mode)
        MODE_PUSH: begin
          if (int'(bc_q) + 8 <= W) begin
            window_d = window_q | push_bits;
            bc_d     = bc_q + BcW'(8);
          end
        end
        MODE_START: begin
          range_d = RANGE_INIT;
          cnt_d   = CntW'(1);
          state_d = ST_BUSY;
        end
        MODE_BOOL: begin
          prob_d  = in_word_i.prob;
          cnt_d   = CntW'(1);
          state_d = ST_BUSY;
        end
        MODE_LITERAL: begin
          cnt_d   = (int'(in_word_i.literal_bits) > MAX_LITERAL_BITS)
                    ? CntW'(MAX_LITERAL_BITS) : CntW'(in_word_i.literal_bits);
          state_d = ST_BUSY;
        end
        default: ;
      endcase
    end
    if (step) begin
      range_d  = dec_range;
      window_d = dec_window;
      bc_d     = bc_sh;
      cnt_d    = cnt_q - CntW'(1);
      acc_d    = {acc_q[14:0], dec_bit};
      under_d  = under_q | dec_under;
    end
    if (finish) state_d = ST_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      range_q     <= RANGE_INIT;
      window_q    <= '0;
      bc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      range_q  <= range_d;
      window_q <= window_d;
      bc_q     <= bc_d;
      if (finish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    prob_q  <= prob_d;
    acc_q   <= acc_d;
    under_q <= under_d;
    if (finish) begin
      out_word_q.value    <= acc_d;
      out_word_q.underrun <= under_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- bench/vp9bd_checker.sv -----
// ----------------------------------------------------------------------------
// vp9bd_checker
// Watches both channels of the boolean decoder core. Every accepted input
// word is run through a local model of range, window and fill count; the
// predicted result words are queued and matched in order against the output.
// ----------------------------------------------------------------------------
module vp9bd_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  vp9bd_pkg::vp9bd_in_t  in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  vp9bd_pkg::vp9bd_out_t out_word_i,
  output int                    err_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import vp9bd_pkg::*;

  localparam int WB     = WINDOW_BITS_DEF;
  localparam int MAXLIT = MAX_LITERAL_BITS_DEF;

  logic [7:0]    rng_q   = RANGE_INIT;
  logic [WB-1:0] win_q   = '0;
  int unsigned   fill_q  = 0;
  logic          short_q = 1'b0;
  vp9bd_out_t    due_q[$];
  int            errs    = 0;
  int            seen    = 0;

  assign err_count_o = errs;
  assign checked_o   = seen;

  // normalise, split, compare: one binary decision
  function logic decide_bit(input logic [7:0] p);
    int unsigned   sh;
    int unsigned   r;
    int unsigned   split;
    logic [WB-1:0] split_v;
    logic          b;
    sh = 0;
    r  = rng_q;
    if (r != 0) begin
      while (r < 128) begin
        r = r << 1;
        sh++;
      end
    end
    r     = r & 32'hFF;
    win_q = win_q << sh;
    fill_q = (sh > fill_q) ? 0 : fill_q - sh;
    if (fill_q < 8) short_q = 1'b1;
    split   = (r * p + (256 - p)) >> 8;
    split_v = '0;
    split_v[WB-1 -: 8] = 8'(split);
    b = (win_q >= split_v);
    if (b) begin
      rng_q = 8'(r - split);
      win_q = win_q - split_v;
    end else begin
      rng_q = 8'(split);
    end
    return b;
  endfunction

  always @(posedge clk_i) begin : watch
    vp9bd_out_t  want;
    logic [15:0] acc;
    int unsigned n;
    if (!rst_ni) begin
      rng_q  = RANGE_INIT;
      win_q  = '0;
      fill_q = 0;
      due_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_q.size() == 0) begin
          $error("unexpected result: value %0h underrun %0b",
                 out_word_i.value, out_word_i.underrun);
          errs++;
        end else begin
          want = due_q.pop_front();
          seen++;
          if (out_word_i.value !== want.value) begin
            $error("value: expected %0h, got %0h", want.value, out_word_i.value);
            errs++;
          end
          if (out_word_i.underrun !== want.underrun) begin
            $error("underrun: expected %0b, got %0b", want.underrun,
                   out_word_i.underrun);
            errs++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        short_q = 1'b0;
        acc     = '0;
        case (in_word_i.mode)
          MODE_PUSH: begin
            if (fill_q + 8 <= WB) begin
              win_q  = win_q | (WB'(in_word_i.data_byte) << (WB - 8 - fill_q));
              fill_q = fill_q + 8;
            end
          end
          MODE_START: begin
            rng_q  = RANGE_INIT;
            acc[0] = decide_bit(PROB_HALF);
          end
          MODE_BOOL: begin
            acc[0] = decide_bit(in_word_i.prob);
          end
          default: begin
            n = (in_word_i.literal_bits > MAXLIT) ? MAXLIT : in_word_i.literal_bits;
            for (int i = 0; i < n; i++) acc = {acc[14:0], decide_bit(PROB_HALF)};
          end
        endcase
        if (in_word_i.mode != MODE_PUSH) begin
          want.value    = acc;
          want.underrun = short_q;
          due_q.push_back(want);
        end
      end
    end
    pending_o <= due_q.size();
  end

endmodule

// ----- bench/tb_vp9_bool_decoder_core.sv -----
// ----------------------------------------------------------------------------
// tb_vp9_bool_decoder_core
// Drives the boolean decoder core with a directed opening (empty stream,
// window overflow, probability extremes, literal lengths) followed by random
// frames of pushes, a start and mixed decodes, plus noise. Both channels idle
// at random; the checker alongside predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_vp9_bool_decoder_core;

  timeunit 1ns;
  timeprecision 1ps;

  import vp9bd_pkg::*;

  localparam int N_RANDOM = 900;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  vp9bd_in_t  in_word_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  vp9bd_out_t out_word_o;

  int   err_count;
  int   pending;
  int   checked;
  int   words_sent = 0;
  logic calm       = 1'b0;

  vp9_bool_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  vp9bd_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_i  (out_word_o),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 21);
  end

  initial begin
    #5ms;
    $display("vp9_bool_decoder_core: mismatch");
    $finish;
  end

  function automatic vp9bd_in_t mk_word(input logic [1:0] m, input logic [7:0] b,
                                        input logic [7:0] p, input logic [4:0] n);
    vp9bd_in_t w;
    w.mode         = m;
    w.data_byte    = b;
    w.prob         = p;
    w.literal_bits = n;
    return w;
  endfunction

  // unused fields carry random bits as well
  function automatic vp9bd_in_t rand_word(input logic [1:0] m);
    vp9bd_in_t w;
    w      = vp9bd_in_t'($urandom);
    w.mode = m;
    return w;
  endfunction

  task automatic send_word(input vp9bd_in_t w);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic send_decode();
    vp9bd_in_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      w = rand_word(MODE_PUSH);
    end else if (pick < 70) begin
      w = rand_word(MODE_BOOL);
      case ($urandom_range(0, 7))
        0: w.prob = 8'd0;
        1: w.prob = 8'd255;
        2: w.prob = 8'd1;
        default: ;
      endcase
    end else if (pick < 97) begin
      w = rand_word(MODE_LITERAL);
      w.literal_bits = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(1, 6));
    end else begin
      w = rand_word(MODE_START);
    end
    send_word(w);
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stream: start and a zero-length literal
    send_word(mk_word(MODE_START, 8'hFF, 8'hFF, 5'd31));
    send_word(mk_word(MODE_LITERAL, 8'h00, 8'h00, 5'd0));
    // nine bytes: the last no longer fits the window
    send_word(mk_word(MODE_PUSH, 8'hFF, 8'h00, 5'd0));
    send_word(mk_word(MODE_PUSH, 8'h00, 8'hFF, 5'd31));
    send_word(mk_word(MODE_PUSH, 8'h5A, 8'h00, 5'd0));
    send_word(mk_word(MODE_PUSH, 8'hC3, 8'h00, 5'd0));
    send_word(mk_word(MODE_PUSH, 8'h81, 8'h00, 5'd0));
    send_word(mk_word(MODE_PUSH, 8'h7E, 8'h00, 5'd0));
    send_word(mk_word(MODE_PUSH, 8'h12, 8'h00, 5'd0));
    send_word(mk_word(MODE_PUSH, 8'hED, 8'h00, 5'd0));
    send_word(mk_word(MODE_PUSH, 8'hFF, 8'h00, 5'd0));
    send_word(mk_word(MODE_START, 8'h00, 8'h00, 5'd0));
    send_word(mk_word(MODE_BOOL, 8'h00, 8'd0, 5'd0));
    send_word(mk_word(MODE_BOOL, 8'h00, 8'd255, 5'd0));
    send_word(mk_word(MODE_BOOL, 8'h00, 8'd1, 5'd0));
    send_word(mk_word(MODE_BOOL, 8'h00, 8'd128, 5'd0));
    send_word(mk_word(MODE_LITERAL, 8'h00, 8'h00, 5'd1));
    send_word(mk_word(MODE_LITERAL, 8'h00, 8'h00, 5'd16));
    send_word(mk_word(MODE_LITERAL, 8'h00, 8'h00, 5'd17));
    // data runs out inside this one
    send_word(mk_word(MODE_LITERAL, 8'h00, 8'h00, 5'd31));
    send_word(mk_word(MODE_BOOL, 8'h00, 8'd255, 5'd0));
    send_word(mk_word(MODE_BOOL, 8'h00, 8'd1, 5'd0));

    while (words_sent < N_RANDOM + 22) begin
      calm = (words_sent > 350) && (words_sent < 500);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(3, 12)) send_word(vp9bd_in_t'($urandom));
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 8);
        repeat (n) send_word(rand_word(MODE_PUSH));
        send_word(rand_word(MODE_START));
        repeat ($urandom_range(4, 20)) send_decode();
      end
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d words (pushes, starts, bools, literals) and checked %0d results.",
             words_sent, checked);
    if (err_count == 0 && pending == 0) begin
      $display("vp9_bool_decoder_core: match");
    end else begin
      $display("vp9_bool_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/vp9bd_pkg.sv
sv/vp9_bool_decoder_core.sv
bench/vp9bd_checker.sv
bench/tb_vp9_bool_decoder_core.sv
